// File: rtl/core/fsgs_pkg.sv
// Shared constants and types for the fraction stream GCD statistics block.
package fsgs_pkg;

    localparam int VALUE_BITS = 16;
    localparam int BASE_BITS  = 24;
    localparam int COUNT_BITS = 11;
    localparam int RSUM_BITS  = 26;
    localparam int WSUM_BITS  = 52;
    localparam int CMP_BITS   = 2 * VALUE_BITS;
    localparam int PROD_BITS  = VALUE_BITS + BASE_BITS;

    localparam logic [BASE_BITS-1:0] BASE_RESET = BASE_BITS'(2*2*3*3*5*5*7*7*13);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_L,
        ST_MUL_R,
        ST_CMP,
        ST_GCD,
        ST_DIV_RED,
        ST_WAIT_RED,
        ST_WAIT_Q,
        ST_MUL_W,
        ST_ACC,
        ST_EMIT
    } fsgs_state_t;

endpackage

// File: rtl/core/fsgs_stream_if.sv
// Valid/ready stream interfaces for fraction words and statistics words.
interface fsgs_in_if
    import fsgs_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] numerator;
    logic [VALUE_BITS-1:0] denominator;
    logic                  last;

    modport source (output valid, numerator, denominator, last, input ready);
    modport sink   (input valid, numerator, denominator, last, output ready);
endinterface

interface fsgs_out_if
    import fsgs_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] min_numerator;
    logic [VALUE_BITS-1:0] min_denominator;
    logic [COUNT_BITS-1:0] irreducible_count;
    logic [RSUM_BITS-1:0]  reduced_sum;
    logic [WSUM_BITS-1:0]  common_sum;

    modport source (output valid, min_numerator, min_denominator, irreducible_count,
                    reduced_sum, common_sum, input ready);
    modport sink   (input valid, min_numerator, min_denominator, irreducible_count,
                    reduced_sum, common_sum, output ready);
endinterface

// File: rtl/core/fsgs_div.sv
// Restoring divider, one quotient bit per cycle.
module fsgs_div
    import fsgs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [BASE_BITS-1:0]  dividend,
    input  logic [VALUE_BITS-1:0] divisor,
    output logic                  done,
    output logic [BASE_BITS-1:0]  quotient
);

    localparam int CNT_BITS = $clog2(BASE_BITS + 1);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_BITS-1:0]   cnt_reg, cnt_next;
    logic [VALUE_BITS-1:0] rem_reg, rem_next;
    logic [BASE_BITS-1:0]  quo_reg, quo_next;
    logic [VALUE_BITS-1:0] dsr_reg, dsr_next;
    logic [VALUE_BITS:0]   trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        trial     = {rem_reg, quo_reg[BASE_BITS-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_BITS'(BASE_BITS);
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next = VALUE_BITS'(trial - {1'b0, dsr_reg});
                quo_next = {quo_reg[BASE_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[VALUE_BITS-1:0];
                quo_next = {quo_reg[BASE_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: rtl/core/fraction_stream_gcd_stats.sv
// Fraction batch statistics: running minimum, coprime count and two sums, one result per batch.
// Each fraction word runs the subtractive GCD one subtract-or-swap step at a time (the step
// count grows with n/d, up to about 65k for 65535/1), makes two passes of the shared
// restoring divider (n/gcd, then common_base/d) and three passes of the shared 16x24
// multiplier. frac.ready is high only between words. The statistics word of a batch sits
// in an output register, so the next batch can start while it waits to be taken.
// common_base resets to 573300 and is written by cfg_wr_en.
module fraction_stream_gcd_stats
    import fsgs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [BASE_BITS-1:0] cfg_wr_data,
    fsgs_in_if.sink              frac,
    fsgs_out_if.source           stats
);

    fsgs_state_t state_reg, state_next;

    logic [BASE_BITS-1:0]  base_reg;
    logic [VALUE_BITS-1:0] num_reg, num_next;
    logic [VALUE_BITS-1:0] den_reg, den_next;
    logic                  last_reg, last_next;
    logic [VALUE_BITS-1:0] gx_reg, gx_next;
    logic [VALUE_BITS-1:0] gy_reg, gy_next;
    logic [BASE_BITS-1:0]  q_reg, q_next;
    logic [PROD_BITS-1:0]  prod_reg, prod_next;
    logic [CMP_BITS-1:0]   lhs_reg, lhs_next;

    logic [VALUE_BITS-1:0] best_num_reg, best_num_next;
    logic [VALUE_BITS-1:0] best_den_reg, best_den_next;
    logic                  have_best_reg, have_best_next;
    logic [COUNT_BITS-1:0] tally_reg, tally_next;
    logic [RSUM_BITS-1:0]  rsum_reg, rsum_next;
    logic [WSUM_BITS-1:0]  wsum_reg, wsum_next;

    logic                  out_valid_reg, out_valid_next;
    logic [VALUE_BITS-1:0] out_num_reg, out_num_next;
    logic [VALUE_BITS-1:0] out_den_reg, out_den_next;
    logic [COUNT_BITS-1:0] out_cnt_reg, out_cnt_next;
    logic [RSUM_BITS-1:0]  out_rsum_reg, out_rsum_next;
    logic [WSUM_BITS-1:0]  out_wsum_reg, out_wsum_next;

    logic [VALUE_BITS-1:0] mul_a;
    logic [BASE_BITS-1:0]  mul_b;
    logic                  div_start;
    logic [BASE_BITS-1:0]  div_dividend;
    logic [VALUE_BITS-1:0] div_divisor;
    logic                  div_done;
    logic [BASE_BITS-1:0]  div_quotient;
    logic [VALUE_BITS-1:0] red;
    logic [RSUM_BITS:0]    rsum_add;
    logic [WSUM_BITS:0]    wsum_add;

    fsgs_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= BASE_RESET;
        end
        else if (cfg_wr_en)
        begin
            base_reg <= cfg_wr_data;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        num_next       = num_reg;
        den_next       = den_reg;
        last_next      = last_reg;
        gx_next        = gx_reg;
        gy_next        = gy_reg;
        q_next         = q_reg;
        lhs_next       = lhs_reg;
        best_num_next  = best_num_reg;
        best_den_next  = best_den_reg;
        have_best_next = have_best_reg;
        tally_next     = tally_reg;
        rsum_next      = rsum_reg;
        wsum_next      = wsum_reg;
        out_valid_next = out_valid_reg && !stats.ready;
        out_num_next   = out_num_reg;
        out_den_next   = out_den_reg;
        out_cnt_next   = out_cnt_reg;
        out_rsum_next  = out_rsum_reg;
        out_wsum_next  = out_wsum_reg;
        div_start      = 1'b0;
        div_dividend   = {{(BASE_BITS-VALUE_BITS){1'b0}}, num_reg};
        div_divisor    = gx_reg;
        mul_a          = num_reg;
        mul_b          = {{(BASE_BITS-VALUE_BITS){1'b0}}, best_den_reg};
        red            = (gx_reg != '0) ? div_quotient[VALUE_BITS-1:0] : '0;
        rsum_add       = {1'b0, rsum_reg} + {{(RSUM_BITS+1-VALUE_BITS){1'b0}}, red};
        wsum_add       = {1'b0, wsum_reg} + {{(WSUM_BITS+1-PROD_BITS){1'b0}}, prod_reg};

        case (state_reg)
            ST_IDLE:
            begin
                if (frac.valid)
                begin
                    num_next   = frac.numerator;
                    den_next   = frac.denominator;
                    last_next  = frac.last;
                    gx_next    = frac.numerator;
                    gy_next    = frac.denominator;
                    state_next = ST_MUL_L;
                end
            end
            ST_MUL_L:
            begin
                state_next = ST_MUL_R;
            end
            ST_MUL_R:
            begin
                mul_a      = best_num_reg;
                mul_b      = {{(BASE_BITS-VALUE_BITS){1'b0}}, den_reg};
                lhs_next   = prod_reg[CMP_BITS-1:0];
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (!have_best_reg || lhs_reg < prod_reg[CMP_BITS-1:0])
                begin
                    best_num_next  = num_reg;
                    best_den_next  = den_reg;
                    have_best_next = 1'b1;
                end
                state_next = ST_GCD;
            end
            ST_GCD:
            begin
                if (gy_reg == '0)
                begin
                    state_next = ST_DIV_RED;
                end
                else if (gx_reg >= gy_reg)
                begin
                    gx_next = gx_reg - gy_reg;
                end
                else
                begin
                    gx_next = gy_reg;
                    gy_next = gx_reg;
                end
            end
            ST_DIV_RED:
            begin
                div_start  = 1'b1;
                state_next = ST_WAIT_RED;
            end
            ST_WAIT_RED:
            begin
                if (div_done)
                begin
                    if (gx_reg == VALUE_BITS'(1) && tally_reg != '1)
                    begin
                        tally_next = tally_reg + 1'b1;
                    end
                    rsum_next    = rsum_add[RSUM_BITS] ? '1 : rsum_add[RSUM_BITS-1:0];
                    div_start    = 1'b1;
                    div_dividend = base_reg;
                    div_divisor  = den_reg;
                    state_next   = ST_WAIT_Q;
                end
            end
            ST_WAIT_Q:
            begin
                if (div_done)
                begin
                    q_next     = (den_reg != '0) ? div_quotient : '0;
                    state_next = ST_MUL_W;
                end
            end
            ST_MUL_W:
            begin
                mul_b      = q_reg;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                wsum_next  = wsum_add[WSUM_BITS] ? '1 : wsum_add[WSUM_BITS-1:0];
                state_next = last_reg ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || stats.ready)
                begin
                    out_valid_next = 1'b1;
                    out_num_next   = best_num_reg;
                    out_den_next   = best_den_reg;
                    out_cnt_next   = tally_reg;
                    out_rsum_next  = rsum_reg;
                    out_wsum_next  = wsum_reg;
                    best_num_next  = '0;
                    best_den_next  = '0;
                    have_best_next = 1'b0;
                    tally_next     = '0;
                    rsum_next      = '0;
                    wsum_next      = '0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        prod_next = PROD_BITS'(mul_a) * PROD_BITS'(mul_b);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            best_num_reg  <= '0;
            best_den_reg  <= '0;
            have_best_reg <= 1'b0;
            tally_reg     <= '0;
            rsum_reg      <= '0;
            wsum_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            best_num_reg  <= best_num_next;
            best_den_reg  <= best_den_next;
            have_best_reg <= have_best_next;
            tally_reg     <= tally_next;
            rsum_reg      <= rsum_next;
            wsum_reg      <= wsum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg      <= num_next;
        den_reg      <= den_next;
        last_reg     <= last_next;
        gx_reg       <= gx_next;
        gy_reg       <= gy_next;
        q_reg        <= q_next;
        prod_reg     <= prod_next;
        lhs_reg      <= lhs_next;
        out_num_reg  <= out_num_next;
        out_den_reg  <= out_den_next;
        out_cnt_reg  <= out_cnt_next;
        out_rsum_reg <= out_rsum_next;
        out_wsum_reg <= out_wsum_next;
    end

    assign frac.ready              = (state_reg == ST_IDLE);
    assign stats.valid             = out_valid_reg;
    assign stats.min_numerator     = out_num_reg;
    assign stats.min_denominator   = out_den_reg;
    assign stats.irreducible_count = out_cnt_reg;
    assign stats.reduced_sum       = out_rsum_reg;
    assign stats.common_sum        = out_wsum_reg;

`ifndef SYNTHESIS
    a_div_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_WAIT_RED || state_reg == ST_WAIT_Q))
        else $error("divider finished outside a wait state");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        frac.valid && frac.ready |=> !frac.ready)
        else $error("accepted a word while the previous one was in progress");

    a_emit_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && state_next == ST_IDLE) |=> stats.valid && !have_best_reg)
        else $error("batch end did not load the output register or clear state");
`endif

endmodule
